// File: rtl/core/bvh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvh_pkg
// Shared types, constants and the byte-wide division step for the binomial
// valuation histogram core.
// ----------------------------------------------------------------------------
package bvh_pkg;

  localparam int VALUE_W  = 64;
  localparam int RADIX_W  = 5;
  localparam int BUCKET_W = 6;
  localparam int SIZE_W   = 64;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int QBYTES_W = 4;

  localparam logic RADIX_IDX = 1'b0;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INIT,
    CELL_SUM,
    CELL_UPD,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t         mode;
    logic [RADIX_W-1:0] digit;
    logic [RADIX_W-1:0] pdiff;
  } cell_ctl_t;

  typedef struct packed {
    logic               done;
    logic [RADIX_W-1:0] digit;
    logic               zero;
  } div_stat_t;

  typedef struct packed {
    logic [7:0]         q;
    logic [RADIX_W-1:0] r;
  } div_step_t;

  // Eight restoring steps: divide {r_in, b} by p, r_in < p.
  function automatic div_step_t div_byte(input logic [RADIX_W-1:0] r_in,
                                         input logic [7:0] b,
                                         input logic [RADIX_W-1:0] p);
    logic [RADIX_W:0]   t;
    logic [RADIX_W-1:0] r;
    div_step_t          res;
    r = r_in;
    res.q = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {r, b[i]};
      if (t >= {1'b0, p}) begin
        t = t - {1'b0, p};
        res.q[i] = 1'b1;
      end
      r = t[RADIX_W-1:0];
    end
    res.r = r;
    return res;
  endfunction

  // Number of bytes up to and including the highest nonzero one.
  function automatic logic [QBYTES_W-1:0] sig_bytes(input logic [VALUE_W-1:0] v);
    logic [QBYTES_W-1:0] n;
    n = '0;
    for (int i = 0; i < VALUE_W / 8; i++) begin
      if (v[i*8 +: 8] != 8'd0) n = QBYTES_W'(i + 1);
    end
    return n;
  endfunction

endpackage

// File: rtl/core/bvh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvh_if
// Request channels of the histogram core: value in, histogram buckets out.
// ----------------------------------------------------------------------------
interface bvh_item_if;
  import bvh_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value_m;
  modport source (output valid, output value_m, input ready);
  modport sink   (input valid, input value_m, output ready);
endinterface

interface bvh_bucket_if;
  import bvh_pkg::*;
  logic                valid;
  logic                ready;
  logic [BUCKET_W-1:0] borrow_count;
  logic [SIZE_W-1:0]   bucket_size;
  logic                last_bucket;
  modport source (output valid, output borrow_count, output bucket_size,
                  output last_bucket, input ready);
  modport sink   (input valid, input borrow_count, input bucket_size,
                  input last_bucket, output ready);
endinterface

// File: rtl/core/binomial_valuation_histogram_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binomial_valuation_histogram_core
// Borrow-count histogram of C(m,t) over t = 0..m in radix p.
//
//   channel   dir  handshake         payload
//   item      in   valid/ready       value_m
//   bucket    out  valid/ready       borrow_count, bucket_size, last_bucket
//   apb       in   psel/penable      paddr, pwdata (radix at 0x0), prdata
//
// One item at a time. Per digit: a start step, divider steps over the
// significant bytes of the remaining quotient (none for a zero value), then
// hand-off, sum and update; then one bucket per cycle while the output is not
// stalled. Worst case is radix 2 with a full 64-bit value; the byte-serial
// divider dominates. Reset clears control only; the cell chain is
// initialized when an item is taken. A stalled bucket holds the drain.
// ----------------------------------------------------------------------------
module binomial_valuation_histogram_core #(
  parameter int MAX_DIGITS  = 64,
  parameter int COUNT_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  bvh_item_if.sink                         item,
  bvh_bucket_if.source                     bucket,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bvh_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [bvh_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [bvh_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bvh_pkg::*;

  localparam int K_W    = $clog2(MAX_DIGITS);
  localparam int NDIG_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SUM, S_UPD, S_EMIT} state_t;

  state_t              state;
  logic [RADIX_W-1:0]  radix;
  logic [RADIX_W-1:0]  p;
  logic [RADIX_W-1:0]  digit;
  logic                last_digit;
  logic [NDIG_W-1:0]   ndig;
  logic [K_W-1:0]      k;
  logic                div_go;

  div_stat_t           dstat;
  cell_ctl_t           ctl;
  logic                accept;
  logic                out_free;
  logic                k_last;

  logic [COUNT_WIDTH-1:0] cell_a  [MAX_DIGITS];
  logic [COUNT_WIDTH-1:0] cell_wb [MAX_DIGITS];

  // configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RADIX_IDX) ? CFG_DATA_W'(radix) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (psel && penable && pwrite && paddr[2] == RADIX_IDX) begin
      radix <= pwdata[RADIX_W-1:0];
    end
  end

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !bucket.valid || bucket.ready;
  assign k_last     = (NDIG_W'(k) + NDIG_W'(1)) == ndig;

  always_comb begin
    ctl.digit = digit;
    ctl.pdiff = p - digit;
    ctl.mode  = CELL_HOLD;
    unique case (state)
      S_IDLE: if (accept) ctl.mode = CELL_INIT;
      S_SUM:  ctl.mode = CELL_SUM;
      S_UPD:  ctl.mode = CELL_UPD;
      S_EMIT: if (out_free) ctl.mode = CELL_SHIFT;
      default: ;
    endcase
  end

  bvh_digit_div u_div (
    .clk   (clk),
    .rst   (rst),
    .load  (accept),
    .value (item.value_m),
    .go    (div_go),
    .radix (p),
    .stat  (dstat)
  );

  for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
    logic [COUNT_WIDTH-1:0] a_up;
    logic [COUNT_WIDTH-1:0] b_in;
    if (g == 0) begin : g_head
      assign b_in = '0;
    end else begin : g_body
      assign b_in = cell_wb[g-1];
    end
    if (g == MAX_DIGITS - 1) begin : g_tail
      assign a_up = '0;
    end else begin : g_link
      assign a_up = cell_a[g+1];
    end
    bvh_cell #(
      .W    (COUNT_WIDTH),
      .HEAD (g == 0)
    ) u_cell (
      .clk  (clk),
      .ctl  (ctl),
      .a_up (a_up),
      .b_in (b_in),
      .a    (cell_a[g]),
      .wb   (cell_wb[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      div_go       <= 1'b0;
      bucket.valid <= 1'b0;
    end else begin
      div_go <= 1'b0;
      if (bucket.valid && bucket.ready && state != S_EMIT) bucket.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            p      <= (radix < RADIX_MIN) ? RADIX_MIN : radix;
            ndig   <= '0;
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          if (dstat.done) begin
            digit      <= dstat.digit;
            last_digit <= dstat.zero || (ndig == NDIG_W'(MAX_DIGITS - 1));
            ndig       <= ndig + NDIG_W'(1);
            state      <= S_SUM;
          end
        end
        S_SUM: state <= S_UPD;
        S_UPD: begin
          if (last_digit) begin
            k     <= '0;
            state <= S_EMIT;
          end else begin
            div_go <= 1'b1;
            state  <= S_DIV;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            bucket.valid        <= 1'b1;
            bucket.borrow_count <= BUCKET_W'(k);
            bucket.bucket_size  <= SIZE_W'(cell_a[0]);
            bucket.last_bucket  <= k_last;
            k <= k + K_W'(1);
            if (k_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/bvh_digit_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvh_digit_div
// Peels base-p digits off the value, least significant first. Long division
// by p runs one byte per cycle over the significant bytes of the quotient.
// ----------------------------------------------------------------------------
module bvh_digit_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [bvh_pkg::VALUE_W-1:0]   value,
  input  logic                          go,
  input  logic [bvh_pkg::RADIX_W-1:0]   radix,
  output bvh_pkg::div_stat_t            stat
);
  import bvh_pkg::*;

  logic [VALUE_W-1:0]  quot;
  logic [QBYTES_W-1:0] qbytes;
  logic [2:0]          bidx;
  logic [RADIX_W-1:0]  rem;
  logic                topz;
  logic                running;

  logic [7:0]          cur_byte;
  div_step_t           step;
  logic                is_top;
  logic                topz_now;
  logic [QBYTES_W-1:0] qbytes_next;

  always_comb begin
    cur_byte    = quot[bidx*8 +: 8];
    step        = div_byte(rem, cur_byte, radix);
    is_top      = (QBYTES_W'(bidx) == qbytes - QBYTES_W'(1));
    topz_now    = is_top ? (step.q == 8'd0) : topz;
    // quotient loses at most its top byte per division (p < 256)
    qbytes_next = qbytes - QBYTES_W'(topz_now);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      stat.done <= 1'b0;
    end else begin
      stat.done <= 1'b0;
      if (load) begin
        quot    <= value;
        qbytes  <= sig_bytes(value);
        running <= 1'b0;
      end else if (go) begin
        if (qbytes == '0) begin
          stat.done  <= 1'b1;
          stat.digit <= '0;
          stat.zero  <= 1'b1;
        end else begin
          running <= 1'b1;
          bidx    <= 3'(qbytes - QBYTES_W'(1));
          rem     <= '0;
        end
      end else if (running) begin
        quot[bidx*8 +: 8] <= step.q;
        rem  <= step.r;
        topz <= topz_now;
        if (bidx == 3'd0) begin
          running    <= 1'b0;
          qbytes     <= qbytes_next;
          stat.done  <= 1'b1;
          stat.digit <= step.r;
          stat.zero  <= (qbytes_next == '0);
        end else begin
          bidx <= bidx - 3'd1;
        end
      end
    end
  end

endmodule

// File: rtl/core/bvh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvh_cell
// One bucket of the borrow DP: path counts with and without a pending borrow
// for one borrow count. Hands its borrow paths up the chain on each digit
// and its count down the chain while the histogram drains.
// ----------------------------------------------------------------------------
module bvh_cell #(
  parameter int W    = 64,
  parameter bit HEAD = 1'b0
) (
  input  logic               clk,
  input  bvh_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       a_up,
  input  logic [W-1:0]       b_in,
  output logic [W-1:0]       a,
  output logic [W-1:0]       wb
);
  import bvh_pkg::*;

  logic [W-1:0] b;
  logic [W-1:0] s;

  // nb = d*(a+b) + a ; wb(k+1) = (p-d)*(a+b) - a
  assign wb = (s * W'(ctl.pdiff)) - a;

  always_ff @(posedge clk) begin
    unique case (ctl.mode)
      CELL_INIT: begin
        a <= W'(HEAD);
        b <= '0;
      end
      CELL_SUM:   s <= a + b;
      CELL_UPD: begin
        a <= (s * W'(ctl.digit)) + a;
        b <= b_in;
      end
      CELL_SHIFT: a <= a_up;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/bvh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvh_checker
// Port-level checks for the histogram core, bound to the top level.
// ----------------------------------------------------------------------------
module bvh_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           item_valid,
  input logic                           item_ready,
  input logic                           bucket_valid,
  input logic                           bucket_ready,
  input logic [bvh_pkg::BUCKET_W-1:0]   borrow_count,
  input logic [bvh_pkg::SIZE_W-1:0]     bucket_size,
  input logic                           last_bucket
);
  import bvh_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !bucket_valid)
    else $error("bucket valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    bucket_valid && !bucket_ready |=>
      bucket_valid && $stable(borrow_count) && $stable(bucket_size)
      && $stable(last_bucket))
    else $error("stalled bucket changed");

  // one request in flight: busy right after taking a value
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("took a second value while busy");

  // idle with a pending bucket means the histogram is fully drained
  a_idle_only_last: assert property (@(posedge clk) disable iff (rst)
    item_ready && bucket_valid |-> last_bucket)
    else $error("idle before the last bucket");

endmodule

bind binomial_valuation_histogram_core bvh_checker u_bvh_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item.valid),
  .item_ready   (item.ready),
  .bucket_valid (bucket.valid),
  .bucket_ready (bucket.ready),
  .borrow_count (bucket.borrow_count),
  .bucket_size  (bucket.bucket_size),
  .last_bucket  (bucket.last_bucket)
);
